// ----- src/mbcrc_pkg.sv -----
// mbcrc_pkg: shared types, codes and the CRC-16 byte step for the Modbus-RTU frame engine
// no dependencies; compile first
`default_nettype none

package mbcrc_pkg;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  BCAST     = 8'h00;
	localparam logic [7:0]  CNT_MAX   = 8'hFF;
	localparam logic [2:0]  MIN_FRAME = 3'd4;

	// input action codes
	localparam logic ACT_TX = 1'b0;
	localparam logic ACT_RX = 1'b1;

	// result kind codes
	localparam logic KIND_SEND   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// receive status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_ADDR  = 3'd2;
	localparam logic [2:0] ST_CRC   = 3'd3;
	localparam logic [2:0] ST_EXC   = 3'd4;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] code;
		logic [7:0] length;
	} rx_status_t;

	// one input's worth of results: a single entry, or byte then crc low then crc high
	typedef struct packed {
		logic        kind;
		logic        three;
		logic [7:0]  b0;
		logic [15:0] crc;
		logic [2:0]  status;
		logic [7:0]  code;
		logic [7:0]  length;
	} res_t;

	// reflected crc-16, one byte, lsb first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/mbcrc_if.sv -----
// mbcrc_if: valid/ready channel interfaces for input items and results
// depends on nothing; compile after mbcrc_pkg
`default_nettype none

interface mbcrc_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       last;

	modport source(output valid, action, data_byte, last, input ready);
	modport sink(input valid, action, data_byte, last, output ready);
endinterface

interface mbcrc_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] out_byte;
	logic       end_of_run;
	logic [2:0] status;
	logic [7:0] exception_code;
	logic [7:0] frame_length;

	modport source(output valid, kind, out_byte, end_of_run, status, exception_code,
		frame_length, input ready);
	modport sink(input valid, kind, out_byte, end_of_run, status, exception_code,
		frame_length, output ready);
endinterface

`default_nettype wire

// ----- src/mbcrc_tx.sv -----
// mbcrc_tx: transmit-side running crc, restarted after each frame's last byte
// depends on mbcrc_pkg
`default_nettype none

module mbcrc_tx (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output logic      [15:0] crc_next
);

	logic [15:0] crc_q;

	assign crc_next = mbcrc_pkg::crc_step(crc_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mbcrc_pkg::CRC_INIT;
		end else if (fire) begin
			crc_q <= last ? mbcrc_pkg::CRC_INIT : crc_next;
		end
	end

endmodule

`default_nettype wire

// ----- src/mbcrc_rx.sv -----
// mbcrc_rx: receive-side frame checker with two-byte delay line and status priority
// depends on mbcrc_pkg
`default_nettype none

module mbcrc_rx (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   last,
	input  wire logic [7:0]             own_address,
	output mbcrc_pkg::rx_status_t       rx_status
);

	logic [2:0]  seen_q;
	logic [7:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  d0_q;
	logic [7:0]  d1_q;
	logic [7:0]  addr_q;
	logic [7:0]  func_q;
	logic [7:0]  code_q;

	logic [2:0]  seen_n;
	logic [7:0]  count_n;
	logic [15:0] crc_n;
	logic [7:0]  addr_n;
	logic [7:0]  func_n;
	logic [7:0]  code_n;
	logic [15:0] got;

	always_comb begin
		addr_n  = (seen_q == 3'd0) ? data_byte : addr_q;
		func_n  = (seen_q == 3'd1) ? data_byte : func_q;
		code_n  = (seen_q == 3'd2) ? data_byte : code_q;
		// the two newest bytes stay out of the crc
		crc_n   = (seen_q >= 3'd2) ? mbcrc_pkg::crc_step(crc_q, d0_q) : crc_q;
		seen_n  = (seen_q < mbcrc_pkg::MIN_FRAME) ? seen_q + 3'd1 : seen_q;
		count_n = (count_q != mbcrc_pkg::CNT_MAX) ? count_q + 8'd1 : count_q;
		got     = {data_byte, d1_q};

		rx_status.code   = 8'h00;
		rx_status.length = count_n;
		if (seen_n < mbcrc_pkg::MIN_FRAME) begin
			rx_status.status = mbcrc_pkg::ST_SHORT;
		end else if (addr_n != own_address && addr_n != mbcrc_pkg::BCAST) begin
			rx_status.status = mbcrc_pkg::ST_ADDR;
		end else if (crc_n != got) begin
			rx_status.status = mbcrc_pkg::ST_CRC;
		end else if (func_n[7]) begin
			rx_status.status = mbcrc_pkg::ST_EXC;
			rx_status.code   = code_n;
		end else begin
			rx_status.status = mbcrc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 3'd0;
			count_q <= 8'd0;
			crc_q   <= mbcrc_pkg::CRC_INIT;
			d0_q    <= 8'h00;
			d1_q    <= 8'h00;
			addr_q  <= 8'h00;
			func_q  <= 8'h00;
			code_q  <= 8'h00;
		end else if (fire) begin
			if (last) begin
				seen_q  <= 3'd0;
				count_q <= 8'd0;
				crc_q   <= mbcrc_pkg::CRC_INIT;
				d0_q    <= 8'h00;
				d1_q    <= 8'h00;
				addr_q  <= 8'h00;
				func_q  <= 8'h00;
				code_q  <= 8'h00;
			end else begin
				seen_q  <= seen_n;
				count_q <= count_n;
				crc_q   <= crc_n;
				d0_q    <= d1_q;
				d1_q    <= data_byte;
				addr_q  <= addr_n;
				func_q  <= func_n;
				code_q  <= code_n;
			end
		end
	end

	a_seen_cap: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= mbcrc_pkg::MIN_FRAME)
		else $error("receive byte tally above cap");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q < mbcrc_pkg::MIN_FRAME |-> count_q == {5'd0, seen_q})
		else $error("receive count out of step with byte tally");

endmodule

`default_nettype wire

// ----- src/mbcrc_res_buf.sv -----
// mbcrc_res_buf: result register holding one input's results, drained one per transfer
// depends on mbcrc_pkg and mbcrc_out_if
`default_nettype none

module mbcrc_res_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire mbcrc_pkg::res_t res_in,
	output logic                room,
	mbcrc_out_if.source         result
);

	mbcrc_pkg::res_t res_q;
	logic            valid_q;
	logic [1:0]      pos_q;
	logic            last_pos;
	logic            xfer;

	assign last_pos = res_q.three ? (pos_q == 2'd2) : 1'b1;
	assign xfer     = valid_q && result.ready;
	assign room     = !valid_q || (result.ready && last_pos);

	assign result.valid          = valid_q;
	assign result.kind           = res_q.kind;
	assign result.end_of_run     = last_pos;
	assign result.status         = res_q.status;
	assign result.exception_code = res_q.code;
	assign result.frame_length   = res_q.length;

	always_comb begin
		case (pos_q)
			2'd1:    result.out_byte = res_q.crc[7:0];
			2'd2:    result.out_byte = res_q.crc[15:8];
			default: result.out_byte = res_q.b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q   <= 2'd0;
		end else if (xfer) begin
			if (last_pos) begin
				valid_q <= 1'b0;
				pos_q   <= 2'd0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	a_single_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.three |-> pos_q == 2'd0)
		else $error("single result buffer advanced past its entry");

	a_drain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !last_pos |=> valid_q && pos_q == $past(pos_q) + 2'd1)
		else $error("result dropped mid run");

endmodule

`default_nettype wire

// ----- src/modbus_rtu_frame_crc_checker.sv -----
// modbus_rtu_frame_crc_checker: Modbus-RTU transmit crc append and receive frame check
// depends on mbcrc_pkg, mbcrc_if, mbcrc_tx, mbcrc_rx, mbcrc_res_buf
//
//   channel   dir   carries                                                 results
//   item      in    action, data_byte, last                                 -
//   result    out   kind, out_byte, end_of_run, status, exception_code,     0..3 per item
//                   frame_length
//   cfg       in    cfg_we, cfg_wdata (own_address)                         -
//
// an item is registered on transfer, then resolved into the result register once that has room
// transmit bytes give 1 result, transmit last bytes 3, receive last bytes 1, other receive 0
// sustained rate is one item per cycle while the result port is ready, except that a transmit
// last byte holds the next item while the result register drains its byte and both crc bytes one per transfer
// a stalled result port fills the input register, then item.ready drops
// reset clears all crc, receive and handshake state and sets own_address to 1
`default_nettype none

module modbus_rtu_frame_crc_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mbcrc_in_if.sink        item,
	mbcrc_out_if.source     result,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [7:0]  own_address_q;

	logic        no_result;
	logic        room;
	logic        advance;
	logic        load;
	logic [15:0] tx_crc;

	mbcrc_pkg::rx_status_t rx_status;
	mbcrc_pkg::res_t       res;

	assign no_result  = (action_s1 == mbcrc_pkg::ACT_RX) && !last_s1;
	assign advance    = valid_s1 && (no_result || room);
	assign load       = advance && !no_result;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			own_address_q <= 8'h01;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (cfg_we) begin
				own_address_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			byte_s1   <= item.data_byte;
			last_s1   <= item.last;
		end
	end

	mbcrc_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance && action_s1 == mbcrc_pkg::ACT_TX),
		.data_byte (byte_s1),
		.last      (last_s1),
		.crc_next  (tx_crc)
	);

	mbcrc_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance && action_s1 == mbcrc_pkg::ACT_RX),
		.data_byte   (byte_s1),
		.last        (last_s1),
		.own_address (own_address_q),
		.rx_status   (rx_status)
	);

	always_comb begin
		if (action_s1 == mbcrc_pkg::ACT_TX) begin
			res.kind   = mbcrc_pkg::KIND_SEND;
			res.three  = last_s1;
			res.b0     = byte_s1;
			res.crc    = tx_crc;
			res.status = mbcrc_pkg::ST_OK;
			res.code   = 8'h00;
			res.length = 8'h00;
		end else begin
			res.kind   = mbcrc_pkg::KIND_STATUS;
			res.three  = 1'b0;
			res.b0     = 8'h00;
			res.crc    = 16'h0000;
			res.status = rx_status.status;
			res.code   = rx_status.code;
			res.length = rx_status.length;
		end
	end

	mbcrc_res_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res_in (res),
		.room   (room),
		.result (result)
	);

	a_rx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == mbcrc_pkg::ACT_RX && !last_s1 |-> !load)
		else $error("receive byte before frame end produced a result");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(action_s1))
		else $error("pending item lost from input register");

endmodule

`default_nettype wire
